>>> rtl/stpfp_pkg.sv
// Package for the stepper command frame parser.
// Holds the character codes, the result record and the character filter.
// No dependencies.
`default_nettype none

package stpfp_pkg;

  localparam logic [7:0] CH_START   = 8'h3C;  // '<'
  localparam logic [7:0] CH_SEP     = 8'h25;  // '%'
  localparam logic [7:0] CH_END     = 8'h3E;  // '>'
  localparam logic [7:0] CH_LO_A    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_B    = 8'h62;  // 'b'
  localparam logic [7:0] CH_UP_A    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_B    = 8'h42;  // 'B'
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;  // '9'

  localparam logic [15:0] DIGIT_BIAS = 16'd48;

  localparam int unsigned STEP_W = 16;
  localparam int unsigned CHAR_W = 8;

  typedef struct packed {
    logic              frame_done;
    logic [STEP_W-1:0] steps_x;
    logic [STEP_W-1:0] steps_y;
    logic [CHAR_W-1:0] dir_x;
    logic [CHAR_W-1:0] dir_y;
  } result_t;

  // Characters that take part in a frame; everything else is dropped.
  function automatic logic is_accepted(input logic [CHAR_W-1:0] c);
    logic ok;
    ok = 1'b0;
    case (c) inside
      CH_LO_A, CH_LO_B, CH_UP_A, CH_UP_B, CH_SEP, CH_END: ok = 1'b1;
      [CH_DIGIT_0:CH_DIGIT_9]:                            ok = 1'b1;
      default:                                            ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/stepper_command_frame_parser_core.sv
// Stepper command frame parser, top level.
// Parser state, one-pass result logic and a two-entry output stage.
// Depends on stpfp_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_char_in) takes one ASCII character
//   per request. Frames look like '<' X-field '%' Y-field '>'. Each character
//   produces exactly one result request on the output channel
//   (out_valid / out_stall / out_*). out_frame_done is 1 only for the '>'
//   that closes a frame; then out_steps_x/y and out_dir_x/y carry the parsed
//   counts (mod 2^16) and direction bytes, otherwise all payload is zero.
//
//   Throughput: one character per cycle while in_stall is low; the parser state
//   and the result are both computed in the accept cycle by a single shift-add
//   (x10) and a few compares, and registered in the output register or the skid
//   entry. The skid entry behind the output register lets the input keep
//   accepting one more character when the receiver stalls; in_stall rises only
//   once both output entries are full, and is a plain register output.
//
//   Reset (rst_n low, synchronous): the parser returns to idle outside any
//   frame, the held X values and field count clear, and both output entries
//   empty. No result requests are lost or duplicated across receiver stalls.
`default_nettype none

module stepper_command_frame_parser_core
  import stpfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_char_in,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_frame_done,
  output logic [STEP_W-1:0]      out_steps_x,
  output logic [STEP_W-1:0]      out_steps_y,
  output logic [CHAR_W-1:0]      out_dir_x,
  output logic [CHAR_W-1:0]      out_dir_y
);

  // Parser state
  logic              in_frame_r,      in_frame_nxt;
  logic              on_y_field_r,    on_y_field_nxt;
  logic [STEP_W-1:0] field_accum_r,   field_accum_nxt;
  logic [STEP_W-1:0] held_steps_x_r,  held_steps_x_nxt;
  logic [CHAR_W-1:0] held_dir_x_r,    held_dir_x_nxt;
  logic [CHAR_W-1:0] pending_char_r,  pending_char_nxt;
  logic              pending_valid_r, pending_valid_nxt;

  // Output stage: main register plus skid entry
  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r,   out_data_nxt;
  result_t skid_data_r,  skid_data_nxt;

  logic              in_acc;
  logic              out_acc;
  result_t           res;
  logic [CHAR_W-1:0] cur_dir;
  logic [STEP_W-1:0] folded;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  // Direction of the current field: last accepted char, or zero if none.
  assign cur_dir = pending_valid_r ? pending_char_r : '0;

  // Horner step: accum*10 + (pending - 48), wraps mod 2^16
  assign folded = (field_accum_r << 3) + (field_accum_r << 1)
                + ({{(STEP_W-CHAR_W){1'b0}}, pending_char_r} - DIGIT_BIAS);

  // Parser next state and this character's result
  always_comb begin
    in_frame_nxt      = in_frame_r;
    on_y_field_nxt    = on_y_field_r;
    field_accum_nxt   = field_accum_r;
    held_steps_x_nxt  = held_steps_x_r;
    held_dir_x_nxt    = held_dir_x_r;
    pending_char_nxt  = pending_char_r;
    pending_valid_nxt = pending_valid_r;
    res               = '0;

    if (!in_frame_r) begin
      if (in_char_in == CH_START) begin
        in_frame_nxt      = 1'b1;
        on_y_field_nxt    = 1'b0;
        field_accum_nxt   = '0;
        pending_char_nxt  = '0;
        pending_valid_nxt = 1'b0;
      end
    end else if (is_accepted(in_char_in)) begin
      if (in_char_in == CH_SEP) begin
        // second separator in the Y field is dropped
        if (!on_y_field_r) begin
          held_steps_x_nxt  = field_accum_r;
          held_dir_x_nxt    = cur_dir;
          on_y_field_nxt    = 1'b1;
          field_accum_nxt   = '0;
          pending_char_nxt  = '0;
          pending_valid_nxt = 1'b0;
        end
      end else if (in_char_in == CH_END) begin
        res.frame_done = 1'b1;
        if (on_y_field_r) begin
          res.steps_x = held_steps_x_r;
          res.dir_x   = held_dir_x_r;
          res.steps_y = field_accum_r;
          res.dir_y   = cur_dir;
        end else begin
          // no separator seen: Y field is empty
          res.steps_x = field_accum_r;
          res.dir_x   = cur_dir;
        end
        in_frame_nxt      = 1'b0;
        on_y_field_nxt    = 1'b0;
        field_accum_nxt   = '0;
        pending_char_nxt  = '0;
        pending_valid_nxt = 1'b0;
      end else begin
        if (pending_valid_r) begin
          field_accum_nxt = folded;
        end
        pending_char_nxt  = in_char_in;
        pending_valid_nxt = 1'b1;
      end
    end
  end

  // Output/skid steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (out_acc && skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      if (out_valid_r && !out_acc) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      on_y_field_r    <= 1'b0;
      field_accum_r   <= '0;
      held_steps_x_r  <= '0;
      held_dir_x_r    <= '0;
      pending_char_r  <= '0;
      pending_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        in_frame_r      <= in_frame_nxt;
        on_y_field_r    <= on_y_field_nxt;
        field_accum_r   <= field_accum_nxt;
        held_steps_x_r  <= held_steps_x_nxt;
        held_dir_x_r    <= held_dir_x_nxt;
        pending_char_r  <= pending_char_nxt;
        pending_valid_r <= pending_valid_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_done = out_data_r.frame_done;
  assign out_steps_x    = out_data_r.steps_x;
  assign out_steps_y    = out_data_r.steps_y;
  assign out_dir_x      = out_data_r.dir_x;
  assign out_dir_y      = out_data_r.dir_y;

  // ---------------- assertions ----------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_y_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    on_y_field_r |-> in_frame_r)
    else $error("Y field selected outside a frame");

  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_valid_r |-> (pending_char_r == '0))
    else $error("stale pending character");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_r && in_char_in == CH_END) |=> !in_frame_r && out_valid_r)
    else $error("end mark did not close the frame");

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for stepper_command_frame_parser_core.
// A table of directed characters, then random frames and noise, checked against a parser model.
// Depends on stpfp_pkg and the parser core.
`timescale 1ns / 100ps

module tb;
  import stpfp_pkg::*;

  // One directed row: the character, and optionally a result typed in by hand.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              typed;
    result_t           res;
  } dir_row_t;

  localparam int DIR_N = 25;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_frame_done;
  logic [STEP_W-1:0] out_steps_x;
  logic [STEP_W-1:0] out_steps_y;
  logic [CHAR_W-1:0] out_dir_x;
  logic [CHAR_W-1:0] out_dir_y;

  // Parser model state
  bit                frm_open = 1'b0;
  bit                in_y = 1'b0;
  logic [STEP_W-1:0] acc = '0;
  logic [STEP_W-1:0] held_sx = '0;
  logic [CHAR_W-1:0] held_dx = '0;
  logic [CHAR_W-1:0] last_ch = '0;
  bit                last_ok = 1'b0;

  result_t     parsed_q[$];     // expected parser results, oldest first
  dir_row_t    dir_tab[DIR_N];
  int unsigned errors = 0;
  int unsigned sent_chars = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned stall_hold = 0;
  result_t     got, want;

  stepper_command_frame_parser_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_done(out_frame_done),
    .out_steps_x   (out_steps_x),
    .out_steps_y   (out_steps_y),
    .out_dir_x     (out_dir_x),
    .out_dir_y     (out_dir_y)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_dir();
    case ($urandom_range(0, 3))
      0:       return CH_LO_A;
      1:       return CH_LO_B;
      2:       return CH_UP_A;
      default: return CH_UP_B;
    endcase
  endfunction

  function automatic dir_row_t row(input logic [CHAR_W-1:0] ch, input logic typed,
                                   input logic done, input logic [CHAR_W-1:0] dx,
                                   input logic [CHAR_W-1:0] dy);
    dir_row_t v;
    v.ch             = ch;
    v.typed          = typed;
    v.res            = '0;
    v.res.frame_done = done;
    v.res.dir_x      = dx;
    v.res.dir_y      = dy;
    return v;
  endfunction

  // Parser model: advances the state by one character, returns the result it causes.
  function automatic result_t parse_char(input logic [CHAR_W-1:0] c);
    result_t r;
    logic    part;
    r    = '0;
    part = (c == CH_LO_A) || (c == CH_LO_B) || (c == CH_UP_A) || (c == CH_UP_B) ||
           (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || (c == CH_SEP) || (c == CH_END);
    if (!frm_open) begin
      // outside a frame only the start mark matters
      if (c == CH_START) begin
        frm_open  = 1'b1;
        in_y      = 1'b0;
        acc       = '0;
        last_ch   = '0;
        last_ok   = 1'b0;
      end
    end else if (part) begin
      if (c == CH_SEP) begin
        // second separator in a frame does nothing
        if (!in_y) begin
          held_sx = acc;
          held_dx = last_ok ? last_ch : '0;
          in_y    = 1'b1;
          acc     = '0;
          last_ch = '0;
          last_ok = 1'b0;
        end
      end else if (c == CH_END) begin
        r.frame_done = 1'b1;
        if (in_y) begin
          r.steps_x = held_sx;
          r.dir_x   = held_dx;
          r.steps_y = acc;
          r.dir_y   = last_ok ? last_ch : '0;
        end else begin
          // no separator seen: Y field is empty
          r.steps_x = acc;
          r.dir_x   = last_ok ? last_ch : '0;
        end
        frm_open = 1'b0;
        in_y     = 1'b0;
        acc      = '0;
        last_ch  = '0;
        last_ok  = 1'b0;
      end else begin
        // the held character is not the last one, so fold it into the count
        if (last_ok) acc = acc * 16'd10 + {8'h00, last_ch} - DIGIT_BIAS;
        last_ch = c;
        last_ok = 1'b1;
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge. Holds the request until it is taken.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic typed,
                           input result_t typed_res);
    int unsigned gap;
    result_t     r;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid   = 1'b0;
      in_char_in = CHAR_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_char_in = c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = parse_char(c);
    parsed_q.push_back(typed ? typed_res : r);
    sent_chars++;
    @(negedge clk);
  endtask

  task automatic send_field();
    int unsigned n, r;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 10)      n = 0;                       // empty field
    else if (r < 80) n = $urandom_range(0, 5);
    else             n = $urandom_range(6, 14);   // long enough to wrap the count
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 65)      c = CH_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
      else if (r < 85) c = pick_dir();
      else             c = CHAR_W'($urandom);     // mostly ignored, sometimes not
      send_char(c, 1'b0, '0);
    end
    // a direction letter usually closes the field
    if ($urandom_range(0, 9) < 8) send_char(pick_dir(), 1'b0, '0);
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Receiver: random stall stretches, with quiet spells of no stall at all.
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_quiet <= ~rx_quiet;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall || rx_quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 10);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= pick_gap();
    end
  end

  // Result checker: every taken result request against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = {out_frame_done, out_steps_x, out_steps_y, out_dir_x, out_dir_y};
      if (parsed_q.size() == 0) begin
        note_error($sformatf("unexpected result: done=%0d sx=%0d sy=%0d dx=%02h dy=%02h",
                             got.frame_done, got.steps_x, got.steps_y, got.dir_x, got.dir_y));
      end else begin
        want = parsed_q.pop_front();
        if (got.frame_done !== want.frame_done || got.steps_x !== want.steps_x ||
            got.steps_y !== want.steps_y || got.dir_x !== want.dir_x ||
            got.dir_y !== want.dir_y) begin
          note_error($sformatf(
            "want d=%0d sx=%0d sy=%0d dx=%02h dy=%02h, got d=%0d sx=%0d sy=%0d dx=%02h dy=%02h",
            want.frame_done, want.steps_x, want.steps_y, want.dir_x, want.dir_y,
            got.frame_done, got.steps_x, got.steps_y, got.dir_x, got.dir_y));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #1_500_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned k, pause_at, frames;

    // Directed rows. Typed results: ignored characters outside a frame,
    // the empty frame, one-character fields and the missing separator.
    dir_tab[0]  = row(8'h00,     1'b1, 1'b0, '0, '0);       // outside, lowest code
    dir_tab[1]  = row(8'hFF,     1'b1, 1'b0, '0, '0);       // outside, highest code
    dir_tab[2]  = row(CH_END,    1'b1, 1'b0, '0, '0);       // end mark outside a frame
    dir_tab[3]  = row(CH_SEP,    1'b1, 1'b0, '0, '0);       // separator outside a frame
    dir_tab[4]  = row(CH_START,  1'b1, 1'b0, '0, '0);
    dir_tab[5]  = row(CH_END,    1'b1, 1'b1, '0, '0);       // empty frame
    dir_tab[6]  = row(CH_START,  1'b0, 1'b0, '0, '0);
    dir_tab[7]  = row(CH_LO_A,   1'b0, 1'b0, '0, '0);
    dir_tab[8]  = row(CH_SEP,    1'b0, 1'b0, '0, '0);
    dir_tab[9]  = row(CH_LO_B,   1'b0, 1'b0, '0, '0);
    dir_tab[10] = row(CH_END,    1'b1, 1'b1, CH_LO_A, CH_LO_B); // one char per field
    dir_tab[11] = row(CH_START,  1'b0, 1'b0, '0, '0);
    dir_tab[12] = row(CH_START,  1'b0, 1'b0, '0, '0);       // start mark inside a frame
    dir_tab[13] = row(CH_DIGIT_9, 1'b0, 1'b0, '0, '0);
    dir_tab[14] = row(8'hFF,     1'b0, 1'b0, '0, '0);       // junk inside a frame
    dir_tab[15] = row(CH_DIGIT_9, 1'b0, 1'b0, '0, '0);
    dir_tab[16] = row(CH_UP_B,   1'b0, 1'b0, '0, '0);
    dir_tab[17] = row(CH_SEP,    1'b0, 1'b0, '0, '0);
    dir_tab[18] = row(CH_SEP,    1'b0, 1'b0, '0, '0);       // repeated separator
    dir_tab[19] = row(CH_UP_A,   1'b0, 1'b0, '0, '0);       // letter folded as a digit
    dir_tab[20] = row(CH_DIGIT_0, 1'b0, 1'b0, '0, '0);
    dir_tab[21] = row(CH_END,    1'b0, 1'b0, '0, '0);
    dir_tab[22] = row(CH_START,  1'b0, 1'b0, '0, '0);
    dir_tab[23] = row(CH_DIGIT_0 + 8'd5, 1'b0, 1'b0, '0, '0);
    dir_tab[24] = row(CH_END,    1'b1, 1'b1, CH_DIGIT_0 + 8'd5, '0); // missing separator

    // Synchronous reset, released at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_quiet = 1'b1;
    for (k = 0; k < DIR_N; k++) begin
      send_char(dir_tab[k].ch, dir_tab[k].typed, dir_tab[k].res);
      if (k == 10) tx_quiet = 1'b0;
    end

    // Hold off the sender until every directed result is back.
    in_valid = 1'b0;
    while (parsed_q.size() != 0) @(negedge clk);

    // Random part: mostly well-formed frames with random content, plus
    // noise between frames and the odd broken frame.
    pause_at = $urandom_range(10, 60);
    frames   = 0;
    while (sent_chars < 850) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom), 1'b0, '0);
      end
      send_char(CH_START, 1'b0, '0);
      send_field();
      if ($urandom_range(0, 9) != 0) begin
        send_char(CH_SEP, 1'b0, '0);
        if ($urandom_range(0, 19) == 0) send_char(CH_SEP, 1'b0, '0);
        send_field();
      end
      // an unclosed frame now and then; the next start mark is then ignored
      if ($urandom_range(0, 19) != 0) send_char(CH_END, 1'b0, '0);
      frames++;
      if (frames == pause_at) begin
        in_valid = 1'b0;
        while (parsed_q.size() != 0) @(negedge clk);
      end
    end

    in_valid = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> stepper_command_frame_parser_core.f
rtl/stpfp_pkg.sv
rtl/stepper_command_frame_parser_core.sv
test/tb.sv
